// ===== rtl/csts_pkg.sv =====
`timescale 1ns / 1ps

package csts_pkg;

	localparam int ENEMY_SLOTS = 16;
	localparam int NUM_SLOTS   = ENEMY_SLOTS + 2;
	localparam int NUM_CLIENTS = ENEMY_SLOTS + 1;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int CLIENT_W    = $clog2(NUM_CLIENTS);

	localparam int CREDIT_W = 24;
	localparam int THR_W    = 16;
	localparam int RATE_W   = 8;
	localparam int ROUND_W  = 16;
	localparam int DVD_W    = THR_W + 1;

	localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};

	localparam logic [THR_W-1:0]  THR_RESET  = 16'd100;
	localparam logic [RATE_W-1:0] RATE_RESET = 8'd10;

	// item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_PICK  = 2'd2;

	// winner classes
	localparam logic [1:0] CLASS_FIXED = 2'd0;
	localparam logic [1:0] CLASS_MAIN  = 2'd1;
	localparam logic [1:0] CLASS_ENEMY = 2'd2;

	// configuration register indexes
	localparam logic [0:0] REG_ACT_THRESHOLD   = 1'b0;
	localparam logic [0:0] REG_FIXED_SLOT_RATE = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] client_slot;
		logic [7:0] weight;
		logic       present;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  winner_class;
		logic [3:0]  winner_index;
		logic [23:0] winner_credit;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [RATE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [ROUND_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [3:0] enemy_index(input logic [SLOT_W-1:0] slot);
		int e;
		e = int'(slot) - 2;
		return e[3:0];
	endfunction

endpackage

// ===== rtl/csts_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module csts_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csts_pkg::div_req_t req,
	output csts_pkg::div_rsp_t rsp
);
	import csts_pkg::*;

	localparam int DIV_STEPS = DVD_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

	logic [RATE_W-1:0] divisor_q;
	logic [RATE_W-1:0] rem_q;
	logic [DVD_W-1:0]  dq_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RATE_W:0] trial;
	logic [RATE_W:0] diff;
	logic            ge;

	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			dq_q      <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q[ROUND_W-1:0];

endmodule

// ===== rtl/credit_turn_scheduler_unit.sv =====
`timescale 1ns / 1ps

// Credit scheduler. Load and clear commands complete in the cycle they are
// taken and never raise busy. A pick holds busy through a scan pass over all
// NUM_SLOTS = ENEMY_SLOTS + 2 slots, in which each present slot still below
// the threshold while the running round count exceeds one runs the shared
// serial divider (17 steps) to find its rounds-to-threshold, then one update
// pass with a single 16x8 multiply-add per slot, then the debit state. The
// winner is shown on result for exactly one cycle with result_valid high, in
// the cycle busy drops; there is no backpressure, so the receiver must take it
// then.
module credit_turn_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  csts_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	output logic                result_valid,
	output csts_pkg::out_item_t result
);
	import csts_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DIVW   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DEBIT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [THR_W-1:0]    thr_q;
	logic [RATE_W-1:0]   fixed_rate_q;
	logic [CREDIT_W-1:0] credit_q [NUM_SLOTS];
	logic [RATE_W-1:0]   weight_q [NUM_CLIENTS];
	logic [NUM_CLIENTS-1:0] present_q;

	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   best_q;
	logic [CREDIT_W-1:0] bestc_q;
	logic [ROUND_W-1:0]  rounds_q;
	logic                result_valid_q;
	out_item_t           result_q;

	logic [CLIENT_W-1:0] cidx;
	logic                slot_act;
	logic [RATE_W-1:0]   raw_rate;
	logic [RATE_W-1:0]   slot_rate;
	logic [CREDIT_W-1:0] cr;
	logic [CREDIT_W-1:0] thr24;
	logic                cr_ge;
	logic [THR_W-1:0]    need;
	logic [CREDIT_W-1:0] prod;
	logic [CREDIT_W:0]   sum;
	logic [CREDIT_W-1:0] newc;
	logic                last;
	logic                load_ok;

	div_req_t div_req;
	div_rsp_t div_rsp;

	always_comb begin
		cidx      = (idx_q == '0) ? '0 : CLIENT_W'(idx_q - 1'b1);
		slot_act  = (idx_q == '0) || present_q[cidx];
		raw_rate  = (idx_q == '0) ? fixed_rate_q : weight_q[cidx];
		slot_rate = (raw_rate == '0) ? RATE_W'(1) : raw_rate;
		cr        = credit_q[idx_q];
		thr24     = {{(CREDIT_W-THR_W){1'b0}}, thr_q};
		cr_ge     = cr >= thr24;
		// only used when cr < thr, so the low bits hold the whole credit
		need      = thr_q - cr[THR_W-1:0];
		prod      = CREDIT_W'(rounds_q) * CREDIT_W'(slot_rate);
		sum       = {1'b0, cr} + {1'b0, prod};
		newc      = sum[CREDIT_W] ? CREDIT_MAX : sum[CREDIT_W-1:0];
		last      = idx_q == SLOT_W'(NUM_SLOTS - 1);
		load_ok   = int'(item.client_slot) < NUM_CLIENTS;
	end

	// ceil(need / rate) as floor((need + rate - 1) / rate)
	always_comb begin
		div_req.start    = (state_q == ST_SCAN) && slot_act && !cr_ge
			&& (rounds_q != ROUND_W'(1));
		div_req.dividend = {1'b0, need} + {{(DVD_W-RATE_W){1'b0}}, slot_rate} - DVD_W'(1);
		div_req.divisor  = slot_rate;
	end

	csts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			thr_q          <= THR_RESET;
			fixed_rate_q   <= RATE_RESET;
			for (int i = 0; i < NUM_SLOTS; i++) credit_q[i] <= '0;
			for (int i = 0; i < NUM_CLIENTS; i++) weight_q[i] <= RATE_W'(1);
			present_q      <= NUM_CLIENTS'(1);
			idx_q          <= '0;
			best_q         <= '0;
			bestc_q        <= '0;
			rounds_q       <= '1;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACT_THRESHOLD:   thr_q <= cfg_wdata;
					REG_FIXED_SLOT_RATE: fixed_rate_q <= cfg_wdata[RATE_W-1:0];
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (item.kind)
							KIND_LOAD: begin
								if (load_ok) begin
									weight_q[CLIENT_W'(item.client_slot)]  <= item.weight;
									present_q[CLIENT_W'(item.client_slot)] <= item.present;
								end
							end
							KIND_CLEAR: begin
								for (int i = 0; i < NUM_SLOTS; i++) credit_q[i] <= '0;
							end
							KIND_PICK: begin
								state_q  <= ST_SCAN;
								idx_q    <= '0;
								rounds_q <= '1;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (div_req.start) begin
						state_q <= ST_DIVW;
					end else begin
						if (slot_act && cr_ge) rounds_q <= ROUND_W'(1);
						if (last) begin
							state_q <= ST_UPDATE;
							idx_q   <= '0;
							best_q  <= '0;
							bestc_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient < rounds_q) rounds_q <= div_rsp.quotient;
						if (last) begin
							state_q <= ST_UPDATE;
							idx_q   <= '0;
							best_q  <= '0;
							bestc_q <= '0;
						end else begin
							state_q <= ST_SCAN;
							idx_q   <= idx_q + 1'b1;
						end
					end
				end
				ST_UPDATE: begin
					if (slot_act) begin
						credit_q[idx_q] <= newc;
						// strict compare keeps the earliest slot on ties
						if (newc >= thr24 && newc > bestc_q) begin
							bestc_q <= newc;
							best_q  <= idx_q;
						end
					end
					if (last) state_q <= ST_DEBIT;
					else idx_q <= idx_q + 1'b1;
				end
				ST_DEBIT: begin
					credit_q[best_q] <= bestc_q - thr24;
					result_valid_q   <= 1'b1;
					state_q          <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DEBIT) begin
			result_q.winner_credit <= bestc_q;
			if (best_q == SLOT_W'(0)) begin
				result_q.winner_class <= CLASS_FIXED;
				result_q.winner_index <= '0;
			end else if (best_q == SLOT_W'(1)) begin
				result_q.winner_class <= CLASS_MAIN;
				result_q.winner_index <= '0;
			end else begin
				result_q.winner_class <= CLASS_ENEMY;
				result_q.winner_index <= enemy_index(best_q);
			end
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_result_after_debit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_DEBIT))
		else $error("result without debit step");

	a_div_not_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_rounds_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> rounds_q != '0)
		else $error("zero round count in update pass");

	a_pick_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == KIND_PICK) |=> busy)
		else $error("pick transfer did not start work");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import csts_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;  // undefined kind, block drops it
	localparam int SETTLE = 2 * NUM_SLOTS + 1 + 18 * NUM_SLOTS + 16;
	localparam int QUIET_LIMIT = 5000;

	logic                clk;
	logic                arst_n;
	logic                start = 1'b0;
	logic                busy;
	in_item_t            item = '0;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_index = '0;
	logic [15:0]         cfg_wdata = '0;
	logic                result_valid;
	out_item_t           result;

	credit_turn_scheduler_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result)
	);

	// shadow of the scheduler
	logic [CREDIT_W-1:0] credit_bal [NUM_SLOTS];
	logic [RATE_W-1:0]   client_wt  [NUM_CLIENTS];
	logic                client_on  [NUM_CLIENTS];
	logic [THR_W-1:0]    act_thr    = THR_RESET;
	logic [RATE_W-1:0]   fixed_rate = RATE_RESET;

	in_item_t  cmd_queue[$];
	out_item_t winner_due[$];

	int  idle_pct = 21;
	int  fails = 0;
	int  quiet = 0;
	bit  took = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int s = 0; s < NUM_SLOTS; s++)
			credit_bal[s] = '0;
		for (int c = 0; c < NUM_CLIENTS; c++) begin
			client_wt[c] = 8'd1;
			client_on[c] = (c == 0);
		end
	end

	function automatic bit slot_live(input int s);
		return (s == 0) ? 1'b1 : client_on[s-1];
	endfunction

	function automatic logic [RATE_W-1:0] slot_step(input int s);
		logic [RATE_W-1:0] w;
		w = (s == 0) ? fixed_rate : client_wt[s-1];
		return (w == '0) ? 8'd1 : w;
	endfunction

	task automatic sched_apply(input in_item_t cmd);
		int unsigned rounds;
		int unsigned r;
		int unsigned need;
		longint unsigned c;
		int best;
		logic [CREDIT_W-1:0] best_c;
		out_item_t win;
		case (cmd.kind)
			KIND_LOAD: begin
				if (cmd.client_slot < NUM_CLIENTS) begin
					client_wt[cmd.client_slot] = cmd.weight;
					client_on[cmd.client_slot] = cmd.present;
				end
			end
			KIND_CLEAR: begin
				for (int s = 0; s < NUM_SLOTS; s++)
					credit_bal[s] = '0;
			end
			KIND_PICK: begin
				// closed form: fewest rounds for any live slot to reach the threshold
				rounds = 32'hFFFF_FFFF;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (slot_live(s)) begin
						if (credit_bal[s] >= act_thr) begin
							r = 1;
						end else begin
							need = act_thr - credit_bal[s];
							r = (need + slot_step(s) - 1) / slot_step(s);
							if (r == 0)
								r = 1;
						end
						if (r < rounds)
							rounds = r;
					end
				end
				best = 0;
				best_c = '0;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (slot_live(s)) begin
						c = 64'(credit_bal[s]) + 64'(rounds) * 64'(slot_step(s));
						if (c > 64'(CREDIT_MAX))
							c = 64'(CREDIT_MAX);
						credit_bal[s] = c[CREDIT_W-1:0];
						if (credit_bal[s] >= act_thr && credit_bal[s] > best_c) begin
							best_c = credit_bal[s];
							best = s;
						end
					end
				end
				credit_bal[best] = best_c - act_thr;
				win.winner_credit = best_c;
				if (best == 0) begin
					win.winner_class = CLASS_FIXED;
					win.winner_index = '0;
				end else if (best == 1) begin
					win.winner_class = CLASS_MAIN;
					win.winner_index = '0;
				end else begin
					win.winner_class = CLASS_ENEMY;
					win.winner_index = 4'(best - 2);
				end
				winner_due.push_back(win);
			end
			default: ;
		endcase
	endtask

	// driver: present the head command, hold it until the transfer
	always @(negedge clk) begin
		if (!(start && !took)) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				item <= cmd_queue[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results first, so a same-edge pick cannot mask a stray strobe
	always @(posedge clk) begin
		out_item_t want;
		took = 1'b0;
		if (arst_n) begin
			if (result_valid) begin
				if (winner_due.size() == 0) begin
					$error("result with no pick outstanding: class %0d index %0d credit %0d",
						result.winner_class, result.winner_index, result.winner_credit);
					fails++;
				end else begin
					want = winner_due.pop_front();
					if (result.winner_class !== want.winner_class) begin
						$error("winner_class expected %0d actual %0d",
							want.winner_class, result.winner_class);
						fails++;
					end
					if (result.winner_index !== want.winner_index) begin
						$error("winner_index expected %0d actual %0d",
							want.winner_index, result.winner_index);
						fails++;
					end
					if (result.winner_credit !== want.winner_credit) begin
						$error("winner_credit expected %0d actual %0d",
							want.winner_credit, result.winner_credit);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				took = 1'b1;
				sched_apply(cmd_queue.pop_front());
			end
			if (took || result_valid)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[credit_turn_scheduler_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic push_cmd(input logic [1:0] kind, input int slot, input int weight,
			input bit present);
		in_item_t c;
		c.kind = kind;
		c.client_slot = 5'(slot);
		c.weight = 8'(weight);
		c.present = present;
		cmd_queue.push_back(c);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACT_THRESHOLD)
			act_thr = val;
		else
			fixed_rate = val[7:0];
	endtask

	// block is idle once nothing is queued, owed or in flight
	task automatic drain();
		while (cmd_queue.size() != 0 || winner_due.size() != 0 || start || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_setting(input logic [15:0] thr, input logic [15:0] rate_word,
			input int n);
		in_item_t c;
		int roll;
		write_reg(REG_ACT_THRESHOLD, thr);
		write_reg(REG_FIXED_SLOT_RATE, rate_word);
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			c = 16'($urandom);
			if (roll < 40) begin
				c.kind = KIND_LOAD;
				c.client_slot = 5'($urandom_range(NUM_CLIENTS - 1));
				c.present = ($urandom_range(99) < 75);
				case ($urandom_range(9))
					0: c.weight = 8'd0;
					1: c.weight = 8'd255;
					default: ;
				endcase
			end else if (roll < 44) begin
				c.kind = KIND_LOAD;
				c.client_slot = 5'($urandom_range(31, NUM_CLIENTS));
			end else if (roll < 47) begin
				c.kind = KIND_CLEAR;
			end else if (roll < 50) begin
				c.kind = KIND_NONE;
			end else begin
				c.kind = KIND_PICK;
			end
			cmd_queue.push_back(c);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset defaults
		idle_pct = 21;
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_LOAD, 0, 10, 1);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_LOAD, 0, 0, 1);        // zero weight counts as one
		push_cmd(KIND_LOAD, 16, 255, 1);     // last enemy
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_LOAD, 17, 255, 1);     // out of range, dropped
		push_cmd(KIND_LOAD, 31, 170, 1);
		push_cmd(KIND_NONE, 21, 85, 1);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_CLEAR, 0, 0, 0);
		push_cmd(KIND_LOAD, 1, 10, 1);
		push_cmd(KIND_LOAD, 0, 10, 1);
		push_cmd(KIND_LOAD, 16, 255, 0);     // absent, keeps its credit
		push_cmd(KIND_PICK, 0, 0, 0);        // three-way tie, fixed slot first
		push_cmd(KIND_PICK, 0, 0, 0);        // main beats enemy 0 on a tie
		push_cmd(KIND_LOAD, 16, 255, 1);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_LOAD, 2, 128, 1);
		push_cmd(KIND_LOAD, 8, 1, 1);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_CLEAR, 0, 0, 0);
		push_cmd(KIND_PICK, 0, 0, 0);
		drain();

		// zero threshold: one round, nothing debited
		write_reg(REG_ACT_THRESHOLD, 16'd0);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_PICK, 0, 0, 0);
		drain();

		// zero fixed rate, only the fixed slot live
		write_reg(REG_ACT_THRESHOLD, 16'd100);
		write_reg(REG_FIXED_SLOT_RATE, 16'hA500);
		push_cmd(KIND_CLEAR, 0, 0, 0);
		for (int c = 0; c < NUM_CLIENTS; c++)
			push_cmd(KIND_LOAD, c, 0, 0);
		push_cmd(KIND_PICK, 0, 0, 0);
		push_cmd(KIND_LOAD, 0, 255, 1);
		push_cmd(KIND_LOAD, 5, 7, 1);
		push_cmd(KIND_LOAD, 12, 200, 1);
		push_cmd(KIND_PICK, 0, 0, 0);
		drain();

		run_setting(16'd100, 16'd10, 128);
		run_setting(16'd65535, 16'd1, 128);
		run_setting(16'd1, 16'hFFFF, 128);

		idle_pct = 58;
		run_setting(16'd65535, 16'd255, 128);
		run_setting(16'd1, 16'd1, 128);
		run_setting(16'($urandom_range(65535, 1)), 16'($urandom), 128);

		idle_pct = 0;
		run_setting(16'($urandom_range(65535, 1)), 16'($urandom), 128);
		run_setting(16'd500, 16'd37, 128);
		run_setting(16'($urandom_range(4000, 1)), 16'($urandom_range(255, 1)), 128);

		if (fails == 0)
			$display("[credit_turn_scheduler_unit] OK");
		else
			$display("[credit_turn_scheduler_unit] ERROR");
		$finish;
	end

endmodule
